@@ rtl/core/rpfh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfh_pkg
// Shared constants and types of the ray to polygon first-hit core.
// ----------------------------------------------------------------------------
package rpfh_pkg;

  localparam int MAX_POINTS = 128;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int PC_W       = 8;
  localparam int IDX_W      = 7;
  localparam int COORD_W    = 18;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PA_W       = COORD_W + DIFF_W;
  localparam int PB_W       = 2 * DIFF_W;
  localparam int DEN_W      = PA_W + 1;
  localparam int TN_W       = PB_W + 1;
  localparam int SN_W       = PA_W + 1;
  localparam int DEN_MAG_W  = DEN_W - 1;
  localparam int TN_MAG_W   = TN_W - 1;

  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 24;
  localparam int SAT_SHIFT  = DIST_W - FRAC_W;
  localparam int SAT_W      = DEN_MAG_W + SAT_SHIFT;
  localparam int QCNT_W     = $clog2(DIST_W + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic [DEN_MAG_W-1:0] den;
    logic [TN_MAG_W-1:0]  tn;
    logic                 sat;
  } cand_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

endpackage

@@ rtl/core/ray_polygon_first_hit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_polygon_first_hit_core
// Ray against closed polygon: nearest positive crossing distance.
// ----------------------------------------------------------------------------
// A load word writes one vertex. A query word reads the vertex store one point
// per cycle through its single read port, unless the divider is busy with a
// pending candidate; each edge the ray actually crosses goes through the
// bit-serial divider that turns the crossing into a Q8.16 distance. Input is
// stalled while a query runs; the result sits in an output register, so the
// next word is taken while it waits.
// ----------------------------------------------------------------------------
module ray_polygon_first_hit_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpfh_pkg::PC_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [rpfh_pkg::IDX_W-1:0]          vertex_index_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] origin_y_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] dir_x_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] dir_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [rpfh_pkg::DIST_W-1:0]         distance_o
);

  rpfh_pkg::state_e state_q, state_d;

  logic [rpfh_pkg::PC_W-1:0]           point_count_q;
  logic [rpfh_pkg::CNT_W-1:0]          n_q, n_d;
  logic [rpfh_pkg::CNT_W-1:0]          addr_q, addr_d;
  logic                                rd_valid_q, rd_first_q;
  logic signed [rpfh_pkg::COORD_W-1:0] org_x_q, org_y_q, dir_x_q, dir_y_q;
  logic                                best_hit_q, best_hit_d;
  logic [rpfh_pkg::DIST_W-1:0]         best_q, best_d;
  logic                                out_valid_q, out_valid_d;
  logic                                hit_q, hit_d;
  logic [rpfh_pkg::DIST_W-1:0]         dist_q, dist_d;

  logic                                in_acc, load_we, query_start;
  logic                                adv, rd_en, fin, out_free;
  rpfh_pkg::vertex_t                   wvert, rvert;
  logic                                cand_valid, pipe_busy;
  rpfh_pkg::cand_t                     cand;
  logic                                div_start, div_busy, div_done;
  logic [rpfh_pkg::DIST_W-1:0]         div_quot;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign load_we     = in_acc && (kind_i == rpfh_pkg::KIND_LOAD)
                    && (32'(vertex_index_i) < rpfh_pkg::MAX_POINTS);
  assign query_start = in_acc && (kind_i == rpfh_pkg::KIND_QUERY);
  assign in_stall_o  = (state_q != rpfh_pkg::ST_IDLE);

  assign adv       = !(cand_valid && div_busy);
  assign rd_en     = (state_q == rpfh_pkg::ST_WALK) && adv && (addr_q < n_q);
  assign div_start = adv && cand_valid;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fin       = (state_q == rpfh_pkg::ST_WALK) && (addr_q == n_q) && !rd_valid_q
                  && !pipe_busy && !div_busy && !div_done;

  assign wvert.x = vertex_x_i;
  assign wvert.y = vertex_y_i;

  rpfh_vertex_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (rpfh_pkg::ADDR_W'(vertex_index_i)),
    .wdata_i (wvert),
    .re_i    (rd_en),
    .raddr_i (addr_q[rpfh_pkg::ADDR_W-1:0]),
    .rdata_o (rvert)
  );

  rpfh_edge_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .vin_valid_i  (rd_valid_q),
    .vin_first_i  (rd_first_q),
    .vin_i        (rvert),
    .org_x_i      (org_x_q),
    .org_y_i      (org_y_q),
    .dir_x_i      (dir_x_q),
    .dir_y_i      (dir_y_q),
    .cand_valid_o (cand_valid),
    .cand_o       (cand),
    .busy_o       (pipe_busy)
  );

  rpfh_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cand_i  (cand),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    addr_d      = addr_q;
    best_hit_d  = best_hit_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    hit_d       = hit_q;
    dist_d      = dist_q;
    case (state_q)
      rpfh_pkg::ST_IDLE: begin
        if (query_start) begin
          if (32'(point_count_q) > rpfh_pkg::MAX_POINTS) begin
            n_d = rpfh_pkg::CNT_W'(rpfh_pkg::MAX_POINTS);
          end else begin
            n_d = rpfh_pkg::CNT_W'(point_count_q);
          end
          addr_d     = '0;
          best_hit_d = 1'b0;
          best_d     = rpfh_pkg::DIST_MAX;
          state_d    = rpfh_pkg::ST_WALK;
        end
      end
      rpfh_pkg::ST_WALK: begin
        if (rd_en) begin
          addr_d = addr_q + rpfh_pkg::CNT_W'(1);
        end
        if (div_done && (!best_hit_q || (div_quot < best_q))) begin
          best_d = div_quot;
        end
        if (div_done) begin
          best_hit_d = 1'b1;
        end
        if (fin && out_free) begin
          out_valid_d = 1'b1;
          hit_d       = best_hit_q;
          dist_d      = best_hit_q ? best_q : '0;
          state_d     = rpfh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpfh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rpfh_pkg::ST_IDLE;
      point_count_q <= '0;
      n_q           <= '0;
      addr_q        <= '0;
      rd_valid_q    <= 1'b0;
      rd_first_q    <= 1'b0;
      best_hit_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      addr_q      <= addr_d;
      best_hit_q  <= best_hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if (adv) begin
        rd_valid_q <= rd_en;
        rd_first_q <= (addr_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    hit_q  <= hit_d;
    dist_q <= dist_d;
    if (query_start) begin
      org_x_q <= origin_x_i;
      org_y_q <= origin_y_i;
      dir_x_q <= dir_x_i;
      dir_y_q <= dir_y_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign distance_o  = dist_q;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpfh_pkg::ST_IDLE) |-> (!pipe_busy && !div_busy && !rd_valid_q))
    else $error("edge work outstanding while idle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (distance_o == '0))
    else $error("miss word carries a distance");
`endif

endmodule

@@ rtl/core/rpfh_vertex_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfh_vertex_mem
// Vertex store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpfh_vertex_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [rpfh_pkg::ADDR_W-1:0]  waddr_i,
  input  rpfh_pkg::vertex_t            wdata_i,
  input  logic                         re_i,
  input  logic [rpfh_pkg::ADDR_W-1:0]  raddr_i,
  output rpfh_pkg::vertex_t            rdata_o
);

  rpfh_pkg::vertex_t mem_q [rpfh_pkg::MAX_POINTS];
  rpfh_pkg::vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rpfh_edge_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfh_edge_pipe
// Edge pipeline: differences, cross products, sign fold and hit test.
// ----------------------------------------------------------------------------
module rpfh_edge_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                vin_valid_i,
  input  logic                                vin_first_i,
  input  rpfh_pkg::vertex_t                   vin_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] org_x_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] org_y_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] dir_x_i,
  input  logic signed [rpfh_pkg::COORD_W-1:0] dir_y_i,
  output logic                                cand_valid_o,
  output rpfh_pkg::cand_t                     cand_o,
  output logic                                busy_o
);

  rpfh_pkg::vertex_t prev_q;

  logic e_valid_q, m_valid_q, s_valid_q, n_valid_q, q_valid_q;

  logic signed [rpfh_pkg::DIFF_W-1:0] ex_d, ey_d, ox_d, oy_d;
  logic signed [rpfh_pkg::DIFF_W-1:0] ex_q, ey_q, ox_q, oy_q;

  logic signed [rpfh_pkg::PA_W-1:0] p_dxey_d, p_dyex_d, p_oydx_d, p_oxdy_d;
  logic signed [rpfh_pkg::PA_W-1:0] p_dxey_q, p_dyex_q, p_oydx_q, p_oxdy_q;
  logic signed [rpfh_pkg::PB_W-1:0] p_oyex_d, p_oxey_d;
  logic signed [rpfh_pkg::PB_W-1:0] p_oyex_q, p_oxey_q;

  logic signed [rpfh_pkg::DEN_W-1:0] den_d, den_q, den_n_d, den_n_q;
  logic signed [rpfh_pkg::TN_W-1:0]  tn_d, tn_q, tn_n_d, tn_n_q;
  logic signed [rpfh_pkg::SN_W-1:0]  sn_d, sn_q, sn_n_d, sn_n_q;

  logic            qual_d, qual_q;
  rpfh_pkg::cand_t cand_d, cand_q;

  always_comb begin
    ex_d = rpfh_pkg::DIFF_W'(vin_i.x) - rpfh_pkg::DIFF_W'(prev_q.x);
    ey_d = rpfh_pkg::DIFF_W'(vin_i.y) - rpfh_pkg::DIFF_W'(prev_q.y);
    ox_d = rpfh_pkg::DIFF_W'(org_x_i) - rpfh_pkg::DIFF_W'(prev_q.x);
    oy_d = rpfh_pkg::DIFF_W'(org_y_i) - rpfh_pkg::DIFF_W'(prev_q.y);
  end

  always_comb begin
    p_dxey_d = rpfh_pkg::PA_W'(dir_x_i) * rpfh_pkg::PA_W'(ey_q);
    p_dyex_d = rpfh_pkg::PA_W'(dir_y_i) * rpfh_pkg::PA_W'(ex_q);
    p_oydx_d = rpfh_pkg::PA_W'(oy_q) * rpfh_pkg::PA_W'(dir_x_i);
    p_oxdy_d = rpfh_pkg::PA_W'(ox_q) * rpfh_pkg::PA_W'(dir_y_i);
    p_oyex_d = rpfh_pkg::PB_W'(oy_q) * rpfh_pkg::PB_W'(ex_q);
    p_oxey_d = rpfh_pkg::PB_W'(ox_q) * rpfh_pkg::PB_W'(ey_q);
  end

  always_comb begin
    den_d = rpfh_pkg::DEN_W'(p_dxey_q) - rpfh_pkg::DEN_W'(p_dyex_q);
    tn_d  = rpfh_pkg::TN_W'(p_oyex_q) - rpfh_pkg::TN_W'(p_oxey_q);
    sn_d  = rpfh_pkg::SN_W'(p_oydx_q) - rpfh_pkg::SN_W'(p_oxdy_q);
  end

  // fold the sign of the denominator into all three terms
  always_comb begin
    if (den_q[rpfh_pkg::DEN_W-1]) begin
      den_n_d = -den_q;
      tn_n_d  = -tn_q;
      sn_n_d  = -sn_q;
    end else begin
      den_n_d = den_q;
      tn_n_d  = tn_q;
      sn_n_d  = sn_q;
    end
  end

  always_comb begin
    qual_d = (den_n_q != '0) && !tn_n_q[rpfh_pkg::TN_W-1] && (tn_n_q != '0)
          && !sn_n_q[rpfh_pkg::SN_W-1] && (sn_n_q <= rpfh_pkg::SN_W'(den_n_q));
    cand_d.den = den_n_q[rpfh_pkg::DEN_MAG_W-1:0];
    cand_d.tn  = tn_n_q[rpfh_pkg::TN_MAG_W-1:0];
    cand_d.sat = rpfh_pkg::SAT_W'(tn_n_q[rpfh_pkg::TN_MAG_W-1:0])
              >= {den_n_q[rpfh_pkg::DEN_MAG_W-1:0], rpfh_pkg::SAT_SHIFT'(0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      n_valid_q <= 1'b0;
      q_valid_q <= 1'b0;
      qual_q    <= 1'b0;
    end else if (adv_i) begin
      e_valid_q <= vin_valid_i && !vin_first_i;
      m_valid_q <= e_valid_q;
      s_valid_q <= m_valid_q;
      n_valid_q <= s_valid_q;
      q_valid_q <= n_valid_q;
      qual_q    <= qual_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (vin_valid_i) begin
        prev_q <= vin_i;
      end
      ex_q     <= ex_d;
      ey_q     <= ey_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      p_dxey_q <= p_dxey_d;
      p_dyex_q <= p_dyex_d;
      p_oydx_q <= p_oydx_d;
      p_oxdy_q <= p_oxdy_d;
      p_oyex_q <= p_oyex_d;
      p_oxey_q <= p_oxey_d;
      den_q    <= den_d;
      tn_q     <= tn_d;
      sn_q     <= sn_d;
      den_n_q  <= den_n_d;
      tn_n_q   <= tn_n_d;
      sn_n_q   <= sn_n_d;
      cand_q   <= cand_d;
    end
  end

  assign cand_valid_o = q_valid_q && qual_q;
  assign cand_o       = cand_q;
  assign busy_o       = e_valid_q || m_valid_q || s_valid_q || n_valid_q || q_valid_q;

endmodule

@@ rtl/core/rpfh_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfh_divider
// Restoring divider, one quotient bit per cycle, saturating Q8.16 quotient.
// ----------------------------------------------------------------------------
module rpfh_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  rpfh_pkg::cand_t              cand_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [rpfh_pkg::DIST_W-1:0]  quot_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [rpfh_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic [rpfh_pkg::DEN_MAG_W-1:0]   den_q, den_d;
  logic [rpfh_pkg::DEN_MAG_W-1:0]   rem_q, rem_d;
  logic [rpfh_pkg::DIST_W-1:0]      sh_q, sh_d;
  logic [rpfh_pkg::DIST_W-1:0]      acc_q, acc_d;
  logic [rpfh_pkg::DIST_W-1:0]      quot_q, quot_d;
  logic [rpfh_pkg::DEN_MAG_W:0]     trial;
  logic [rpfh_pkg::DEN_MAG_W:0]     diff;
  logic                             ge;

  always_comb begin
    trial = {rem_q, sh_q[rpfh_pkg::DIST_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    quot_d = quot_q;
    if (start_i) begin
      den_d = cand_i.den;
      rem_d = rpfh_pkg::DEN_MAG_W'(cand_i.tn >> rpfh_pkg::SAT_SHIFT);
      sh_d  = {cand_i.tn[rpfh_pkg::SAT_SHIFT-1:0], rpfh_pkg::FRAC_W'(0)};
      acc_d = '0;
      cnt_d = rpfh_pkg::QCNT_W'(rpfh_pkg::DIST_W);
      if (cand_i.sat) begin
        quot_d = rpfh_pkg::DIST_MAX;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[rpfh_pkg::DEN_MAG_W-1:0] : trial[rpfh_pkg::DEN_MAG_W-1:0];
      sh_d  = {sh_q[rpfh_pkg::DIST_W-2:0], 1'b0};
      acc_d = {acc_q[rpfh_pkg::DIST_W-2:0], ge};
      cnt_d = cnt_q - rpfh_pkg::QCNT_W'(1);
      if (cnt_q == rpfh_pkg::QCNT_W'(1)) begin
        quot_d = acc_d;
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ tb/sv/tb_ray_polygon_first_hit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_polygon_first_hit_core
// Self-checking bench for the ray to polygon first-hit core.
// ----------------------------------------------------------------------------
// Fills the whole vertex store, then walks a short table of hand-picked words:
// empty and one-point polygons, a square hit head on, parallel edges, corner
// hits, rays pointing away or starting on an edge, saturated and sub-LSB
// distances, extreme coordinates and oversized point counts. Random phases
// follow; each sets a point count, loads a closed polygon (scattered or
// axis-aligned) if the count allows two points or more, and casts rays at it,
// with stray loads mixed in. Each result is compared field by field against
// the answer in the table or an untimed model of the core kept in the bench.
// The sender works in bursts and the receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module tb_ray_polygon_first_hit_core;
  import rpfh_pkg::*;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int RANDOM_WORDS = 1500;
  localparam int DRAIN_CYCLES = 24;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_REPORTS  = 40;
  localparam int ONE          = 65536;
  localparam int HALF         = 32768;
  localparam int CMAX         = 131071;
  localparam int CMIN         = -131072;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HOLD,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] vx, vy, ox, oy, dx, dy;
  } word_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } answer_t;

  typedef struct {
    logic            set_count;
    logic [PC_W-1:0] count;
    word_t           w;
    logic            typed;
    answer_t         ans;
  } plan_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [PC_W-1:0]           cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      kind_i;
  logic [IDX_W-1:0]          vertex_index_i;
  logic signed [COORD_W-1:0] vertex_x_i;
  logic signed [COORD_W-1:0] vertex_y_i;
  logic signed [COORD_W-1:0] origin_x_i;
  logic signed [COORD_W-1:0] origin_y_i;
  logic signed [COORD_W-1:0] dir_x_i;
  logic signed [COORD_W-1:0] dir_y_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      hit_o;
  logic [DIST_W-1:0]         distance_o;

  logic signed [COORD_W-1:0] poly_x [MAX_POINTS];
  logic signed [COORD_W-1:0] poly_y [MAX_POINTS];
  logic [PC_W-1:0]           poly_count;
  answer_t                   answers_due [$];
  plan_row_t                 plan [$];
  int                        mismatches;
  int                        words_sent;
  int                        burst_left;
  int unsigned               cycle_count = 0;

  stall_mode_e               stall_mode = STALL_NONE;
  int                        stall_left = 0;
  int                        hold_left = 0;
  int                        stall_tick = 0;

  ray_polygon_first_hit_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .vertex_index_i (vertex_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .distance_o     (distance_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_ray_polygon_first_hit_core NOT OK");
    $finish;
  end

  function automatic answer_t cast_ray(input word_t w);
    answer_t a;
    int      n;
    int      k;
    longint  ax, ay, ex, ey, ox, oy, dx, dy, den, tn, sn, q, best;
    a.hit = 1'b0;
    best  = DIST_MAX;
    dx    = $signed(w.dx);
    dy    = $signed(w.dy);
    n     = (poly_count > MAX_POINTS) ? MAX_POINTS : int'(poly_count);
    for (k = 0; k + 1 < n; k++) begin
      ax  = poly_x[k];
      ay  = poly_y[k];
      ex  = poly_x[k+1];
      ey  = poly_y[k+1];
      ex  = ex - ax;
      ey  = ey - ay;
      ox  = $signed(w.ox);
      oy  = $signed(w.oy);
      ox  = ox - ax;
      oy  = oy - ay;
      den = dx * ey - dy * ex;
      if (den != 0) begin
        tn = oy * ex - ox * ey;
        sn = oy * dx - ox * dy;
        if (den < 0) begin
          den = -den;
          tn  = -tn;
          sn  = -sn;
        end
        if (tn > 0 && sn >= 0 && sn <= den) begin
          q = (tn <<< FRAC_W) / den;
          if (q > DIST_MAX) q = DIST_MAX;
          if (!a.hit || q < best) best = q;
          a.hit = 1'b1;
        end
      end
    end
    a.distance = a.hit ? best[DIST_W-1:0] : '0;
    return a;
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    logic [31:0] r;
    r = $urandom();
    return r[COORD_W-1:0];
  endfunction

  function automatic int jitter(input int base, input int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  function automatic word_t make_word(input logic kind, input int idx,
                                      input int a, input int b, input int c, input int d);
    word_t w;
    w.kind = kind;
    w.idx  = idx[IDX_W-1:0];
    w.vx   = any_coord();
    w.vy   = any_coord();
    w.ox   = any_coord();
    w.oy   = any_coord();
    w.dx   = any_coord();
    w.dy   = any_coord();
    if (kind == KIND_LOAD) begin
      w.vx = a[COORD_W-1:0];
      w.vy = b[COORD_W-1:0];
    end else begin
      w.idx = IDX_W'($urandom_range(0, MAX_POINTS - 1));
      w.ox  = a[COORD_W-1:0];
      w.oy  = b[COORD_W-1:0];
      w.dx  = c[COORD_W-1:0];
      w.dy  = d[COORD_W-1:0];
    end
    return w;
  endfunction

  function automatic void take_word(input word_t w, input logic typed, input answer_t ans);
    words_sent++;
    if (w.kind == KIND_LOAD) begin
      poly_x[w.idx] = w.vx;
      poly_y[w.idx] = w.vy;
    end else begin
      answers_due.push_back(typed ? ans : cast_ray(w));
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic hold_off(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      hold_off($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 100)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic push_word(input word_t w, input logic typed, input answer_t ans);
    in_valid_i     <= 1'b1;
    kind_i         <= w.kind;
    vertex_index_i <= w.idx;
    vertex_x_i     <= w.vx;
    vertex_y_i     <= w.vy;
    origin_x_i     <= w.ox;
    origin_y_i     <= w.oy;
    dir_x_i        <= w.dx;
    dir_y_i        <= w.dy;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    take_word(w, typed, ans);
    pace_sender();
  endtask

  task automatic push_load(input int slot, input int x, input int y);
    push_word(make_word(KIND_LOAD, slot, x, y, 0, 0), 1'b0, '0);
  endtask

  task automatic push_query(input int ox, input int oy, input int dx, input int dy);
    push_word(make_word(KIND_QUERY, 0, ox, oy, dx, dy), 1'b0, '0);
  endtask

  task automatic settle();
    hold_off(1);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [PC_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    poly_count = value;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic add_row(input int set_count, input int count, input logic kind, input int idx,
                         input int a, input int b, input int c, input int d,
                         input int typed, input int hit, input int distance);
    plan_row_t r;
    r.set_count    = (set_count != 0);
    r.count        = count[PC_W-1:0];
    r.w            = make_word(kind, idx, a, b, c, d);
    r.typed        = (typed != 0);
    r.ans.hit      = (hit != 0);
    r.ans.distance = distance[DIST_W-1:0];
    plan.push_back(r);
  endtask

  task automatic run_phase();
    int              pick, m, nq, k, cx, cy, spread, hw, hh, x0, y0, ox, oy, dx, dy;
    logic [PC_W-1:0] count;
    settle();
    pick   = $urandom_range(0, 23);
    cx     = jitter(0, HALF);
    cy     = jitter(0, HALF);
    spread = ($urandom_range(0, 3) == 0) ? ONE / 16 : ($urandom_range(0, 1) ? HALF : ONE);
    if (pick == 0) count = 0;
    else if (pick == 1) count = 1;
    else if (pick == 2) count = MAX_POINTS;
    else if (pick == 3) count = $urandom_range(MAX_POINTS + 1, 255);
    else if (pick < 8) count = 5;
    else count = $urandom_range(2, 17);
    write_count(count);
    m = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
    if (pick >= 4 && pick < 8) begin
      hw = $urandom_range(256, HALF);
      hh = $urandom_range(256, HALF);
      push_load(0, cx - hw, cy - hh);
      push_load(1, cx + hw, cy - hh);
      push_load(2, cx + hw, cy + hh);
      push_load(3, cx - hw, cy + hh);
      push_load(4, cx - hw, cy - hh);
    end else if (m >= 2) begin
      x0 = jitter(cx, spread);
      y0 = jitter(cy, spread);
      push_load(0, x0, y0);
      for (k = 1; k < m - 1; k++) push_load(k, jitter(cx, spread), jitter(cy, spread));
      push_load(m - 1, x0, y0);
    end
    nq = (m >= 64) ? 3 : $urandom_range(6, 30);
    repeat (nq) begin
      if ($urandom_range(0, 9) == 0)
        push_load($urandom_range(0, MAX_POINTS - 1), jitter(0, 2 * ONE), jitter(0, 2 * ONE));
      ox = jitter(cx, spread / 2);
      oy = jitter(cy, spread / 2);
      case ($urandom_range(0, 15))
        0: begin
          ox = jitter(0, 2 * ONE);
          oy = jitter(0, 2 * ONE);
          dx = jitter(0, 2 * ONE);
          dy = jitter(0, 2 * ONE);
        end
        1, 2: begin
          dx = 0;
          dy = 0;
          case ($urandom_range(0, 3))
            0: dx = ONE;
            1: dx = -ONE;
            2: dy = ONE;
            default: dy = -ONE;
          endcase
        end
        3: begin
          dx = jitter(0, 16);
          dy = jitter(0, 16);
        end
        default: begin
          dx = jitter(0, ONE);
          dy = jitter(0, ONE);
        end
      endcase
      push_query(ox, oy, dx, dy);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 400);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      STALL_HOLD: begin
        if (hold_left == 0) begin
          out_stall_i <= ~out_stall_i;
          hold_left = $urandom_range(1, 20);
        end else begin
          hold_left--;
        end
      end
      default: out_stall_i <= ((stall_tick % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result, hit", hit_o, 0);
      end else begin
        want = answers_due.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (distance_o !== want.distance)
          report_mismatch("distance", distance_o, want.distance);
      end
    end
  end

  initial begin
    int random_base;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_LOAD;
    vertex_index_i = '0;
    vertex_x_i     = '0;
    vertex_y_i     = '0;
    origin_x_i     = '0;
    origin_y_i     = '0;
    dir_x_i        = '0;
    dir_y_i        = '0;
    poly_count     = '0;
    mismatches     = 0;
    words_sent     = 0;
    burst_left     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot so no query ever reads an unwritten vertex
    for (int s = 0; s < MAX_POINTS; s++) push_load(s, jitter(0, 2 * ONE), jitter(0, 2 * ONE));

    //      set cnt  kind        slot a          b          c          d        chk hit dist
    add_row(0,  0,   KIND_QUERY, 0,   0,         0,         ONE,       0,       1,  0,  0);
    add_row(1,  1,   KIND_QUERY, 0,   0,         0,         ONE,       0,       1,  0,  0);
    add_row(0,  0,   KIND_LOAD,  0,   -HALF,     -HALF,     0,         0,       0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  1,   HALF,      -HALF,     0,         0,       0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  2,   HALF,      HALF,      0,         0,       0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  3,   -HALF,     HALF,      0,         0,       0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  4,   -HALF,     -HALF,     0,         0,       0,  0,  0);
    add_row(1,  5,   KIND_QUERY, 0,   0,         0,         ONE,       0,       1,  1,  HALF);
    add_row(0,  0,   KIND_QUERY, 0,   0,         0,         0,         -ONE,    1,  1,  HALF);
    add_row(0,  0,   KIND_QUERY, 0,   0,         0,         ONE,       ONE,     0,  0,  0);
    add_row(0,  0,   KIND_QUERY, 0,   -ONE,      0,         ONE,       0,       0,  0,  0);
    add_row(0,  0,   KIND_QUERY, 0,   ONE,       0,         ONE,       0,       1,  0,  0);
    add_row(0,  0,   KIND_QUERY, 0,   0,         0,         1,         0,       1,  1,  DIST_MAX);
    add_row(0,  0,   KIND_QUERY, 0,   HALF - 1,  0,         CMAX,      0,       1,  1,  0);
    add_row(0,  0,   KIND_QUERY, 0,   HALF,      0,         ONE,       0,       1,  0,  0);
    add_row(0,  0,   KIND_QUERY, 0,   0,         0,         0,         0,       1,  0,  0);
    add_row(0,  0,   KIND_QUERY, 0,   CMIN,      CMIN,      CMAX,      CMAX,    0,  0,  0);
    add_row(0,  0,   KIND_QUERY, 0,   CMAX,      CMAX,      CMIN,      CMIN,    0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  127, CMIN,      CMAX,      0,         0,       0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  5,   CMAX,      CMIN,      0,         0,       0,  0,  0);
    add_row(0,  0,   KIND_LOAD,  6,   CMIN,      CMIN,      0,         0,       0,  0,  0);
    add_row(1,  255, KIND_QUERY, 0,   0,         0,         ONE,       HALF,    0,  0,  0);
    add_row(1,  128, KIND_QUERY, 0,   CMIN,      0,         CMAX,      1,       0,  0,  0);
    add_row(1,  2,   KIND_QUERY, 0,   0,         0,         0,         -ONE,    1,  1,  HALF);

    foreach (plan[i]) begin
      if (plan[i].set_count) begin
        settle();
        write_count(plan[i].count);
      end
      push_word(plan[i].w, plan[i].typed, plan[i].ans);
    end

    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) run_phase();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_ray_polygon_first_hit_core OK");
    end else begin
      $display("tb_ray_polygon_first_hit_core NOT OK");
    end
    $finish;
  end

endmodule
